// File: rtl/tpt_pkg.sv
// Shared constants, register indexes and types for the touch point press tracker.
// No dependencies; imported by tpt_axis_map, touch_point_press_tracker, tpt_checker and the testbench.
package tpt_pkg;

  localparam int unsigned CoordW    = 12;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SlopW     = 8;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 64;

  localparam logic [7:0]       CountMask = 8'h0F;
  localparam logic [TimeW-1:0] StaleMs   = 32'd100;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgAxisMode      = 4'd0;
  localparam logic [CfgIndexW-1:0] CfgRawMinX       = 4'd1;
  localparam logic [CfgIndexW-1:0] CfgRawMaxX       = 4'd2;
  localparam logic [CfgIndexW-1:0] CfgRawMinY       = 4'd3;
  localparam logic [CfgIndexW-1:0] CfgRawMaxY       = 4'd4;
  localparam logic [CfgIndexW-1:0] CfgTapSlop       = 4'd5;
  localparam logic [CfgIndexW-1:0] CfgReleaseSlop   = 4'd6;
  localparam logic [CfgIndexW-1:0] CfgSampleInterval = 4'd7;

  // Reset values of the configuration registers
  localparam logic [2:0]           RstAxisMode       = 3'd0;
  localparam logic [CoordW-1:0]    RstRawMinX        = 12'd0;
  localparam logic [CoordW-1:0]    RstRawMaxX        = 12'd479;
  localparam logic [CoordW-1:0]    RstRawMinY        = 12'd0;
  localparam logic [CoordW-1:0]    RstRawMaxY        = 12'd799;
  localparam logic [SlopW-1:0]     RstTapSlop        = 8'd12;
  localparam logic [SlopW-1:0]     RstReleaseSlop    = 8'd24;
  localparam logic [IntervalW-1:0] RstSampleInterval = 16'd10;

  // Per-axis mapping setup handed to the axis mapper
  typedef struct packed {
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    logic              flip;
  } axis_cfg_t;

endpackage

// File: rtl/touch_point_press_tracker.sv
// Top level of the touch point press tracker: poll gating, press tracking, stream ports.
// Depends on tpt_pkg and instantiates tpt_axis_map for each axis.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid_i/tready_o  | tdata: poll bytes, tuser: read_ok
//  m_axis    | out       | m_axis_tvalid_o/tready_i  | tdata: tracker view, tuser: sampled
//  cfg       | in        | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Each word is held in an input register, then decoded and folded into the tracker
// state combinationally while its result is written to the output register, so one word
// passes per cycle unless the output stalls, and each result leaves from the output register.
// The limiting path is the 32-bit time compare and subtract in front of the state.
// A stalled output holds the output register and the input register; a new word is
// still taken into the input register while a result waits, as long as that is empty.
// Reset clears the tracker state to zero and loads the default configuration.
// cfg_ready_o is always high: registers are written in the cycle they are offered.
module touch_point_press_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata, lowest bit up: now_ms[31:0], count_byte[39:32], x_high_byte[47:40],
  // x_low_byte[55:48], y_high_byte[63:56], y_low_byte[71:64]
  input  logic [tpt_pkg::InDataW-1:0]       s_axis_tdata_i,
  // tuser: read_ok
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata, lowest bit up: is_pressed[0], point_valid[1], point_x[13:2],
  // point_y[25:14], press_event[26], release_event[27], held_ms[59:28],
  // beyond_tap[60], beyond_release[61], zero fill[63:62]
  output logic [tpt_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // tuser: sampled
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpt_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [tpt_pkg::CfgDataW-1:0]      cfg_data_i
);
  import tpt_pkg::*;

  // ---------------------------------------------------------------- configuration
  logic [2:0]           axis_mode_q;
  logic [CoordW-1:0]    raw_min_x_q, raw_max_x_q, raw_min_y_q, raw_max_y_q;
  logic [SlopW-1:0]     tap_slop_q, release_slop_q;
  logic [IntervalW-1:0] sample_interval_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_mode_q       <= RstAxisMode;
      raw_min_x_q       <= RstRawMinX;
      raw_max_x_q       <= RstRawMaxX;
      raw_min_y_q       <= RstRawMinY;
      raw_max_y_q       <= RstRawMaxY;
      tap_slop_q        <= RstTapSlop;
      release_slop_q    <= RstReleaseSlop;
      sample_interval_q <= RstSampleInterval;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAxisMode:       axis_mode_q       <= cfg_data_i[2:0];
        CfgRawMinX:        raw_min_x_q       <= cfg_data_i[CoordW-1:0];
        CfgRawMaxX:        raw_max_x_q       <= cfg_data_i[CoordW-1:0];
        CfgRawMinY:        raw_min_y_q       <= cfg_data_i[CoordW-1:0];
        CfgRawMaxY:        raw_max_y_q       <= cfg_data_i[CoordW-1:0];
        CfgTapSlop:        tap_slop_q        <= cfg_data_i[SlopW-1:0];
        CfgReleaseSlop:    release_slop_q    <= cfg_data_i[SlopW-1:0];
        CfgSampleInterval: sample_interval_q <= cfg_data_i;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  logic                s1_valid_q;
  logic [InDataW-1:0]  s1_data_q;
  logic                s1_ok_q;
  logic                out_valid_q;
  logic                advance;

  // Advance the input word whenever the output register is empty or being drained
  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_data_q <= s_axis_tdata_i;
      s1_ok_q   <= s_axis_tuser_i;
    end
  end

  // ---------------------------------------------------------------- field unpack
  logic [TimeW-1:0]  now_ms;
  logic [7:0]        count_byte;
  logic [CoordW-1:0] raw_x, raw_y;
  logic [CoordW-1:0] sel_x, sel_y;

  assign now_ms     = s1_data_q[31:0];
  assign count_byte = s1_data_q[39:32] & CountMask;
  assign raw_x      = {s1_data_q[43:40], s1_data_q[55:48]};
  assign raw_y      = {s1_data_q[59:56], s1_data_q[71:64]};
  // Swap axes before mapping; the x limits always apply to the x output
  assign sel_x      = axis_mode_q[0] ? raw_y : raw_x;
  assign sel_y      = axis_mode_q[0] ? raw_x : raw_y;

  axis_cfg_t         cfg_x, cfg_y;
  logic [CoordW-1:0] map_x, map_y;

  assign cfg_x = '{lo: raw_min_x_q, hi: raw_max_x_q, flip: axis_mode_q[1]};
  assign cfg_y = '{lo: raw_min_y_q, hi: raw_max_y_q, flip: axis_mode_q[2]};

  tpt_axis_map u_map_x (
    .cfg_i   (cfg_x),
    .raw_i   (sel_x),
    .coord_o (map_x)
  );

  tpt_axis_map u_map_y (
    .cfg_i   (cfg_y),
    .raw_i   (sel_y),
    .coord_o (map_y)
  );

  // ---------------------------------------------------------------- tracker state
  logic [TimeW-1:0]  next_sample_q, next_sample_d;
  logic              pressed_q, pressed_d;
  logic              valid_q, valid_d;
  logic [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [TimeW-1:0]  cur_time_q, cur_time_d;
  logic [CoordW-1:0] down_x_q, down_x_d, down_y_q, down_y_d;
  logic [TimeW-1:0]  down_time_q, down_time_d;
  logic              beyond_tap_q, beyond_tap_d;
  logic              beyond_rel_q, beyond_rel_d;
  logic [TimeW-1:0]  last_hold_q, last_hold_d;

  logic              sampled, press_evt, release_evt;
  logic              do_release;
  logic [CoordW-1:0] dx, dy;
  logic [TimeW-1:0]  age;

  assign age = now_ms - cur_time_q;
  assign dx  = (map_x > down_x_q) ? (map_x - down_x_q) : (down_x_q - map_x);
  assign dy  = (map_y > down_y_q) ? (map_y - down_y_q) : (down_y_q - map_y);

  always_comb begin
    next_sample_d = next_sample_q;
    pressed_d     = pressed_q;
    valid_d       = valid_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    cur_time_d    = cur_time_q;
    down_x_d      = down_x_q;
    down_y_d      = down_y_q;
    down_time_d   = down_time_q;
    beyond_tap_d  = beyond_tap_q;
    beyond_rel_d  = beyond_rel_q;
    last_hold_d   = last_hold_q;
    sampled       = 1'b0;
    press_evt     = 1'b0;
    do_release    = 1'b0;

    if (now_ms >= next_sample_q) begin
      sampled       = 1'b1;
      next_sample_d = now_ms + {{(TimeW-IntervalW){1'b0}}, sample_interval_q};
      if (!s1_ok_q) begin
        // Failed read: let go only of a touch whose last point has gone stale
        do_release = pressed_q && (age > StaleMs);
      end else if (count_byte == 8'd0) begin
        do_release = pressed_q;
      end else begin
        valid_d    = 1'b1;
        cur_x_d    = map_x;
        cur_y_d    = map_y;
        cur_time_d = now_ms;
        if (!pressed_q) begin
          pressed_d    = 1'b1;
          press_evt    = 1'b1;
          down_x_d     = map_x;
          down_y_d     = map_y;
          down_time_d  = now_ms;
          beyond_tap_d = 1'b0;
          beyond_rel_d = 1'b0;
        end else begin
          if ((dx > {4'd0, tap_slop_q}) || (dy > {4'd0, tap_slop_q})) begin
            beyond_tap_d = 1'b1;
          end
          if ((dx > {4'd0, release_slop_q}) || (dy > {4'd0, release_slop_q})) begin
            beyond_rel_d = 1'b1;
          end
        end
      end
    end

    if (do_release) begin
      pressed_d   = 1'b0;
      valid_d     = 1'b0;
      last_hold_d = now_ms - down_time_q;
    end
    release_evt = do_release;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_sample_q <= '0;
      pressed_q     <= 1'b0;
      valid_q       <= 1'b0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      cur_time_q    <= '0;
      down_x_q      <= '0;
      down_y_q      <= '0;
      down_time_q   <= '0;
      beyond_tap_q  <= 1'b0;
      beyond_rel_q  <= 1'b0;
      last_hold_q   <= '0;
    end else if (advance) begin
      next_sample_q <= next_sample_d;
      pressed_q     <= pressed_d;
      valid_q       <= valid_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      cur_time_q    <= cur_time_d;
      down_x_q      <= down_x_d;
      down_y_q      <= down_y_d;
      down_time_q   <= down_time_d;
      beyond_tap_q  <= beyond_tap_d;
      beyond_rel_q  <= beyond_rel_d;
      last_hold_q   <= last_hold_d;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [OutDataW-1:0] out_data_q;
  logic                out_sampled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the state as it stands after this word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sampled_q <= sampled;
      out_data_q    <= {2'b00, beyond_rel_d, beyond_tap_d, last_hold_d, release_evt,
                        press_evt, cur_y_d, cur_x_d, valid_d, pressed_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sampled_q;

  // ---------------------------------------------------------------- assertions
  a_no_event_unsampled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_sampled_q |-> !out_data_q[26] && !out_data_q[27])
    else $error("press or release reported for a gated poll");

  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[26] && out_data_q[27]))
    else $error("press and release in the same result");

  a_pressed_has_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressed_q |-> valid_q)
    else $error("touch held without a valid point");

  a_release_drops_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && release_evt |=> !pressed_q && $past(pressed_q))
    else $error("release without a held touch");

  a_gate_holds_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !sampled |=> $stable(next_sample_q) && $stable(pressed_q))
    else $error("gated poll changed tracker state");

endmodule

// File: rtl/tpt_axis_map.sv
// Maps one raw 12-bit axis value onto 0..range with clamping and optional flip.
// Depends on tpt_pkg for coordinate width and the axis_cfg_t struct.
module tpt_axis_map (
  input  tpt_pkg::axis_cfg_t          cfg_i,
  input  logic [tpt_pkg::CoordW-1:0]  raw_i,
  output logic [tpt_pkg::CoordW-1:0]  coord_o
);
  import tpt_pkg::*;

  logic [CoordW-1:0] span;
  logic [CoordW-1:0] mapped;

  always_comb begin
    span = (cfg_i.hi > cfg_i.lo) ? (cfg_i.hi - cfg_i.lo) : '0;
    if ((cfg_i.hi <= cfg_i.lo) || (raw_i <= cfg_i.lo)) begin
      mapped = '0;
    end else if (raw_i >= cfg_i.hi) begin
      mapped = span;
    end else begin
      mapped = raw_i - cfg_i.lo;
    end
    coord_o = cfg_i.flip ? (span - mapped) : mapped;
  end

endmodule

// File: tb/tpt_checker.sv
// Checker for the touch point press tracker: mirrors the tracker state and its registers,
// predicts one view word per accepted poll word and compares it with the output stream.
// Depends on tpt_pkg for widths, register indexes and reset values.
module tpt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tpt_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [tpt_pkg::OutDataW-1:0]  m_axis_tdata_i,
  input  logic                          m_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tpt_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tpt_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            mismatches_o,
  output int                            pending_o
);
  import tpt_pkg::*;

  typedef struct packed {
    logic              sampled;
    logic              is_pressed;
    logic              point_valid;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              press_event;
    logic              release_event;
    logic [TimeW-1:0]  held_ms;
    logic              beyond_tap;
    logic              beyond_release;
  } touch_view_t;

  // Register mirror
  logic [2:0]           axis_mode;
  logic [CoordW-1:0]    min_x, max_x, min_y, max_y;
  logic [SlopW-1:0]     tap_slop, rel_slop;
  logic [IntervalW-1:0] interval;

  // Tracker mirror
  logic [TimeW-1:0]  next_gate, cur_time, down_time, hold_ms;
  logic              held, have_point, tap_mark, rel_mark;
  logic [CoordW-1:0] cur_x, cur_y, down_x, down_y;

  touch_view_t expected_views_q[$];
  touch_view_t predicted, observed;
  int          mismatch_count = 0;

  function automatic logic [CoordW-1:0] axis_span(input logic [CoordW-1:0] lo,
                                                  input logic [CoordW-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // Clamp onto 0..span; an inverted or empty area maps everything to 0
  function automatic logic [CoordW-1:0] map_axis(input logic [CoordW-1:0] raw,
                                                 input logic [CoordW-1:0] lo,
                                                 input logic [CoordW-1:0] hi);
    if (hi <= lo || raw <= lo) return '0;
    if (raw >= hi) return hi - lo;
    return raw - lo;
  endfunction

  function automatic logic [CoordW-1:0] abs_delta(input logic [CoordW-1:0] a,
                                                  input logic [CoordW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic end_touch(input logic [TimeW-1:0] now);
    held       = 1'b0;
    have_point = 1'b0;
    hold_ms    = now - down_time;
  endtask

  task automatic fold_poll(input logic [InDataW-1:0] word, input logic ok,
                           output touch_view_t v);
    logic [TimeW-1:0]  now;
    logic [7:0]        fingers;
    logic [CoordW-1:0] rx, ry, px, py, dx, dy;
    logic              sampled, pressed_now, released_now;
    now          = word[31:0];
    fingers      = word[39:32] & CountMask;
    rx           = {word[43:40], word[55:48]};
    ry           = {word[59:56], word[71:64]};
    sampled      = 1'b0;
    pressed_now  = 1'b0;
    released_now = 1'b0;
    if (now >= next_gate) begin
      sampled   = 1'b1;
      next_gate = now + {16'd0, interval};
      if (!ok) begin
        // a failed read only drops a touch whose last point has gone stale
        if (held && (now - cur_time) > StaleMs) begin
          end_touch(now);
          released_now = 1'b1;
        end
      end else if (fingers == 8'd0) begin
        if (held) begin
          end_touch(now);
          released_now = 1'b1;
        end
      end else begin
        px = map_axis(axis_mode[0] ? ry : rx, min_x, max_x);
        py = map_axis(axis_mode[0] ? rx : ry, min_y, max_y);
        if (axis_mode[1]) px = axis_span(min_x, max_x) - px;
        if (axis_mode[2]) py = axis_span(min_y, max_y) - py;
        have_point = 1'b1;
        cur_x      = px;
        cur_y      = py;
        cur_time   = now;
        if (!held) begin
          held        = 1'b1;
          pressed_now = 1'b1;
          down_x      = px;
          down_y      = py;
          down_time   = now;
          tap_mark    = 1'b0;
          rel_mark    = 1'b0;
        end else begin
          dx = abs_delta(px, down_x);
          dy = abs_delta(py, down_y);
          if (dx > {4'd0, tap_slop} || dy > {4'd0, tap_slop}) tap_mark = 1'b1;
          if (dx > {4'd0, rel_slop} || dy > {4'd0, rel_slop}) rel_mark = 1'b1;
        end
      end
    end
    v.sampled        = sampled;
    v.is_pressed     = held;
    v.point_valid    = have_point;
    v.point_x        = cur_x;
    v.point_y        = cur_y;
    v.press_event    = pressed_now;
    v.release_event  = released_now;
    v.held_ms        = hold_ms;
    v.beyond_tap     = tap_mark;
    v.beyond_release = rel_mark;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_mode  = RstAxisMode;
      min_x      = RstRawMinX;
      max_x      = RstRawMaxX;
      min_y      = RstRawMinY;
      max_y      = RstRawMaxY;
      tap_slop   = RstTapSlop;
      rel_slop   = RstReleaseSlop;
      interval   = RstSampleInterval;
      next_gate  = '0;
      cur_time   = '0;
      down_time  = '0;
      hold_ms    = '0;
      held       = 1'b0;
      have_point = 1'b0;
      tap_mark   = 1'b0;
      rel_mark   = 1'b0;
      cur_x      = '0;
      cur_y      = '0;
      down_x     = '0;
      down_y     = '0;
      expected_views_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgAxisMode:       axis_mode = cfg_data_i[2:0];
          CfgRawMinX:        min_x     = cfg_data_i[CoordW-1:0];
          CfgRawMaxX:        max_x     = cfg_data_i[CoordW-1:0];
          CfgRawMinY:        min_y     = cfg_data_i[CoordW-1:0];
          CfgRawMaxY:        max_y     = cfg_data_i[CoordW-1:0];
          CfgTapSlop:        tap_slop  = cfg_data_i[SlopW-1:0];
          CfgReleaseSlop:    rel_slop  = cfg_data_i[SlopW-1:0];
          CfgSampleInterval: interval  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        fold_poll(s_axis_tdata_i, s_axis_tuser_i, predicted);
        expected_views_q.push_back(predicted);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_views_q.size() == 0) begin
          $error("view word arrived with no poll waiting for it");
          mismatch_count++;
        end else begin
          predicted              = expected_views_q.pop_front();
          observed.sampled        = m_axis_tuser_i;
          observed.is_pressed     = m_axis_tdata_i[0];
          observed.point_valid    = m_axis_tdata_i[1];
          observed.point_x        = m_axis_tdata_i[13:2];
          observed.point_y        = m_axis_tdata_i[25:14];
          observed.press_event    = m_axis_tdata_i[26];
          observed.release_event  = m_axis_tdata_i[27];
          observed.held_ms        = m_axis_tdata_i[59:28];
          observed.beyond_tap     = m_axis_tdata_i[60];
          observed.beyond_release = m_axis_tdata_i[61];
          check_field("sampled", 32'(predicted.sampled), 32'(observed.sampled));
          check_field("is_pressed", 32'(predicted.is_pressed), 32'(observed.is_pressed));
          check_field("point_valid", 32'(predicted.point_valid), 32'(observed.point_valid));
          check_field("point_x", 32'(predicted.point_x), 32'(observed.point_x));
          check_field("point_y", 32'(predicted.point_y), 32'(observed.point_y));
          check_field("press_event", 32'(predicted.press_event),
                      32'(observed.press_event));
          check_field("release_event", 32'(predicted.release_event),
                      32'(observed.release_event));
          check_field("held_ms", predicted.held_ms, observed.held_ms);
          check_field("beyond_tap", 32'(predicted.beyond_tap), 32'(observed.beyond_tap));
          check_field("beyond_release", 32'(predicted.beyond_release),
                      32'(observed.beyond_release));
        end
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= expected_views_q.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the touch point press tracker testbench: clock, reset, poll and register stimulus,
// receiver back-pressure and the final verdict. Depends on tpt_pkg, the tracker RTL and
// tpt_checker, which predicts and compares every view word.
module testbench;
  import tpt_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int ItemsPerPhase = 140;
  localparam int NumPhases     = 8;
  // each result passes the input and output registers before it leaves; settle a little longer
  localparam int SettleCycles  = 4;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;

  logic [InDataW-1:0]   poll_tdata  = '0;
  logic                 poll_tuser  = 1'b0;
  logic                 poll_tvalid = 1'b0;
  logic                 poll_tready;
  logic [OutDataW-1:0]  view_tdata;
  logic                 view_tuser;
  logic                 view_tvalid;
  logic                 view_tready = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index   = '0;
  logic [CfgDataW-1:0]  cfg_data    = '0;

  int mismatches;
  int pending;
  int cycles        = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Our own view of the sample gate and of the registers, used only to shape stimulus
  logic [TimeW-1:0]     next_accept = '0;
  logic [2:0]           shape_axis  = RstAxisMode;
  logic [CoordW-1:0]    shape_min_x = RstRawMinX;
  logic [CoordW-1:0]    shape_max_x = RstRawMaxX;
  logic [CoordW-1:0]    shape_min_y = RstRawMinY;
  logic [CoordW-1:0]    shape_max_y = RstRawMaxY;
  logic [IntervalW-1:0] shape_interval = RstSampleInterval;

  touch_point_press_tracker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (poll_tdata),
    .s_axis_tuser_i  (poll_tuser),
    .s_axis_tvalid_i (poll_tvalid),
    .s_axis_tready_o (poll_tready),
    .m_axis_tdata_o  (view_tdata),
    .m_axis_tuser_o  (view_tuser),
    .m_axis_tvalid_o (view_tvalid),
    .m_axis_tready_i (view_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  tpt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (poll_tdata),
    .s_axis_tuser_i  (poll_tuser),
    .s_axis_tvalid_i (poll_tvalid),
    .s_axis_tready_i (poll_tready),
    .m_axis_tdata_i  (view_tdata),
    .m_axis_tuser_i  (view_tuser),
    .m_axis_tvalid_i (view_tvalid),
    .m_axis_tready_i (view_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Receiver: drop ready at random for the share of cycles the current phase asks
  always @(posedge clk_i) begin
    view_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Watchdog: abandon a run that hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one register word; valid stays high so back-to-back writes need no gap.
  // Bits above the register width carry junk, which the block must mask off.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input int width);
    logic [31:0] junk;
    junk = $urandom << width;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value | junk[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CfgAxisMode:       shape_axis     = value[2:0];
      CfgRawMinX:        shape_min_x    = value[CoordW-1:0];
      CfgRawMaxX:        shape_max_x    = value[CoordW-1:0];
      CfgRawMinY:        shape_min_y    = value[CoordW-1:0];
      CfgRawMaxY:        shape_max_y    = value[CoordW-1:0];
      CfgSampleInterval: shape_interval = value;
      default: ;
    endcase
  endtask

  // Write every register, optionally poke the unused indexes, then drop valid
  task automatic apply_setting(input logic [2:0] axis,
                               input logic [CoordW-1:0] lo_x, input logic [CoordW-1:0] hi_x,
                               input logic [CoordW-1:0] lo_y, input logic [CoordW-1:0] hi_y,
                               input logic [SlopW-1:0] tap, input logic [SlopW-1:0] rel,
                               input logic [IntervalW-1:0] interval, input bit poke_unused);
    write_reg(CfgAxisMode, {13'd0, axis}, 3);
    write_reg(CfgRawMinX, {4'd0, lo_x}, CoordW);
    write_reg(CfgRawMaxX, {4'd0, hi_x}, CoordW);
    write_reg(CfgRawMinY, {4'd0, lo_y}, CoordW);
    write_reg(CfgRawMaxY, {4'd0, hi_y}, CoordW);
    write_reg(CfgTapSlop, {8'd0, tap}, SlopW);
    write_reg(CfgReleaseSlop, {8'd0, rel}, SlopW);
    write_reg(CfgSampleInterval, interval, IntervalW);
    if (poke_unused) begin
      for (int i = int'(CfgSampleInterval) + 1; i < (1 << CfgIndexW); i++) begin
        write_reg(CfgIndexW'(i), 16'($urandom), IntervalW);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Hold the poll side idle until every predicted view word has come out, then settle
  task automatic drain();
    poll_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Send one poll word; the ignored high nibbles of the coordinate bytes are random
  task automatic poll_at(input logic [TimeW-1:0] now, input logic ok, input logic [7:0] cnt_b,
                         input logic [CoordW-1:0] rx, input logic [CoordW-1:0] ry);
    logic [3:0] junk_x, junk_y;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      poll_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    junk_x = 4'($urandom);
    junk_y = 4'($urandom);
    poll_tdata  <= {ry[7:0], junk_y, ry[11:8], rx[7:0], junk_x, rx[11:8], cnt_b, now};
    poll_tuser  <= ok;
    poll_tvalid <= 1'b1;
    do @(posedge clk_i); while (!poll_tready);
    if (now >= next_accept) next_accept = now + {16'd0, shape_interval};
  endtask

  // Pick a poll time: mostly just past the gate, some early (ignored), some stale,
  // some anywhere in the 32-bit range and a few right at the top to force a wrap
  function automatic logic [TimeW-1:0] pick_now();
    int unsigned      roll, back, extra;
    logic [TimeW:0]   sum;
    roll = $urandom_range(99, 0);
    if (roll < 12 && next_accept != '0) begin
      back = $urandom_range(20, 0);
      if (back >= next_accept) back = next_accept - 1;
      return next_accept - 1 - back;
    end
    if (roll < 15) return $urandom;
    if (roll < 17 && shape_interval > 16'd20) return 32'hFFFF_FFFF - $urandom_range(15, 0);
    extra = (roll < 32) ? $urandom_range(400, 80) : $urandom_range(5, 0);
    sum = {1'b0, next_accept} + {1'b0, extra};
    return sum[TimeW] ? 32'hFFFF_FFFF : sum[TimeW-1:0];
  endfunction

  function automatic logic [7:0] count_byte(input logic [3:0] fingers);
    return {4'($urandom), fingers};
  endfunction

  // Half the time anywhere, half the time in or just around the active area
  function automatic logic [CoordW-1:0] aim_coord(input logic [CoordW-1:0] lo,
                                                  input logic [CoordW-1:0] hi);
    int l, h;
    if ($urandom_range(1, 0) == 0) return 12'($urandom);
    l = (lo < hi) ? int'(lo) : int'(hi);
    h = (lo < hi) ? int'(hi) : int'(lo);
    l = (l < 8) ? 0 : l - 8;
    h = (h > 4087) ? 4095 : h + 8;
    return 12'($urandom_range(h, l));
  endfunction

  function automatic logic [CoordW-1:0] nudge(input logic [CoordW-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(60, 0)) - 30;
    if (n < 0) n = 0;
    if (n > 4095) n = 4095;
    return 12'(n);
  endfunction

  // Random strokes: a press, a run of moves with some noise words mixed in, then a lift,
  // a failed read or nothing at all (the next press then lands as a move)
  task automatic run_strokes(input int n_items);
    int                sent, roll;
    logic [CoordW-1:0] fx, fy;
    sent = 0;
    while (sent < n_items) begin
      if (shape_axis[0]) begin
        fx = aim_coord(shape_min_y, shape_max_y);
        fy = aim_coord(shape_min_x, shape_max_x);
      end else begin
        fx = aim_coord(shape_min_x, shape_max_x);
        fy = aim_coord(shape_min_y, shape_max_y);
      end
      poll_at(pick_now(), 1'b1, count_byte(4'($urandom_range(15, 1))), fx, fy);
      sent++;
      repeat ($urandom_range(10, 1)) begin
        roll = int'($urandom_range(99, 0));
        if (roll < 10) begin
          poll_at(pick_now(), 1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
        end else begin
          if (roll < 20) begin
            fx = 12'($urandom);
            fy = 12'($urandom);
          end else begin
            fx = nudge(fx);
            fy = nudge(fy);
          end
          poll_at(pick_now(), 1'b1, count_byte(4'($urandom_range(15, 1))), fx, fy);
        end
        sent++;
      end
      roll = int'($urandom_range(9, 0));
      if (roll < 5) begin
        poll_at(pick_now(), 1'b1, count_byte(4'd0), 12'($urandom), 12'($urandom));
        sent++;
      end else if (roll < 8) begin
        poll_at(pick_now(), 1'b0, 8'($urandom), 12'($urandom), 12'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset settings: gate edges, slop marks, stale reads, wrap
    poll_at(32'd0, 1'b1, 8'h01, 12'd0, 12'd0);            // first press at the origin
    poll_at(32'd5, 1'b1, 8'h01, 12'd100, 12'd100);        // too early: ignored
    poll_at(32'd10, 1'b1, 8'h01, 12'd479, 12'd799);       // exactly on the gate, far move
    poll_at(32'd20, 1'b0, 8'h00, 12'd0, 12'd0);           // failed read, point still fresh
    poll_at(32'd200, 1'b0, 8'h00, 12'd0, 12'd0);          // failed read, stale: release
    poll_at(32'd210, 1'b1, 8'hF0, 12'hFFF, 12'hFFF);      // no fingers while released
    poll_at(32'd220, 1'b1, 8'hF1, 12'hFFF, 12'hFFF);      // press clamped to the far corner
    poll_at(32'd230, 1'b1, 8'h02, 12'd470, 12'd795);      // move within tap slop
    poll_at(32'd240, 1'b1, 8'h03, 12'd459, 12'd799);      // beyond tap, within release
    poll_at(32'd250, 1'b1, 8'h00, 12'd0, 12'd0);          // lift
    poll_at(32'd400, 1'b0, 8'h01, 12'd0, 12'd0);          // failed read while released
    poll_at(32'd500, 1'b1, 8'h0F, 12'd240, 12'd400);      // press with fifteen fingers
    poll_at(32'd600, 1'b0, 8'h01, 12'd0, 12'd0);          // age exactly at the limit: hold
    poll_at(32'd610, 1'b0, 8'h01, 12'd0, 12'd0);          // age past the limit: release
    poll_at(32'hFFFF_FFF0, 1'b1, 8'h01, 12'd10, 12'd10);  // press near the top of time
    poll_at(32'hFFFF_FFFF, 1'b1, 8'h01, 12'd36, 12'd10);  // move past both slops, gate wraps
    poll_at(32'd3, 1'b1, 8'h01, 12'd10, 12'd10);          // below the wrapped gate: ignored
    poll_at(32'd9, 1'b1, 8'h00, 12'd0, 12'd0);            // lift; hold time wraps round

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      case (phase)
        0: ;  // keep the reset settings
        1: apply_setting(3'd1, 12'd100, 12'd3000, 12'd200, 12'd4000, 8'd0, 8'd255, 16'd0,
                         1'b0);
        2: apply_setting(3'd7, 12'd4095, 12'd4095, 12'd0, 12'd4095, 8'd255, 8'd0,
                         16'hFFFF, 1'b0);
        3: apply_setting(3'd2, 12'd3000, 12'd1000, 12'd50, 12'd60, 8'd3, 8'd5, 16'd1, 1'b0);
        4: apply_setting(3'd4, 12'd0, 12'd4095, 12'd4095, 12'd0, 8'd12, 8'd24, 16'd100,
                         1'b0);
        5: apply_setting(3'd3, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                         8'($urandom), 8'($urandom), 16'($urandom_range(200, 0)), 1'b1);
        6: apply_setting(3'd5, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                         8'($urandom), 8'($urandom), 16'($urandom_range(200, 0)), 1'b0);
        default: apply_setting(3'd6, 12'($urandom), 12'($urandom), 12'($urandom),
                               12'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom_range(200, 0)), 1'b0);
      endcase
      // Advance through the idling patterns: none, sender idle, receiver stall, both
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 85;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct    <= 30;
        end
      endcase
      run_strokes(ItemsPerPhase);
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tpt_pkg.sv
rtl/tpt_axis_map.sv
rtl/touch_point_press_tracker.sv
tb/tpt_checker.sv
tb/testbench.sv
